### rtl/core/ssc_pkg.sv
`timescale 1ns / 1ps

package ssc_pkg;

	localparam int ELEM_W   = 16;
	localparam int TARGET_W = 10;
	localparam int RESULT_W = 32;

endpackage

### rtl/core/subset_sum_count_core.sv
`timescale 1ns / 1ps

// subset_sum_count_core
// Counts the subsets of a set of elements whose sum equals target_sum.
// Input stream: one element per beat on s_tdata, s_tlast marks the final
// element of a set. Output stream: one beat per set, sent after the last
// element has been folded in, with the saturated count on m_tdata and the
// sticky saturation flag on m_tuser.
// cfg_wen/cfg_wdata write target_sum; write it only while the core is idle.
// Each element sweeps the whole count table once, top entry down to entry 0,
// one entry per cycle through a two-read, one-write table memory, then passes
// through the DRAIN and FINISH states; s_tready is high only between elements.
// The result beat is registered from FINISH once the output register is free.
// The first element of a set rebuilds the table during its own sweep, so no
// clearing pass is needed after reset or between sets.
// Reset clears the control state; the table contents are left unknown.
// A stalled result beat holds in the output register while the next element
// is accepted and swept; a following result waits until that beat is taken.

module subset_sum_count_core #(
	parameter int MAX_TARGET  = 1023,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ssc_pkg::ELEM_W-1:0]    s_tdata,   // elem_value
	input  logic                          s_tlast,   // last_elem
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ssc_pkg::RESULT_W-1:0]  m_tdata,   // subset_count
	output logic                          m_tuser,   // count_saturated
	input  logic                          cfg_wen,
	input  logic [ssc_pkg::TARGET_W-1:0]  cfg_wdata  // target_sum
);

	import ssc_pkg::*;

	localparam int DEPTH = MAX_TARGET + 1;
	localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           t_q;
	logic [ELEM_W-1:0]       v_q;
	logic                    last_q;
	logic                    first_q;
	logic                    pending_q;
	logic                    sat_q;
	logic [TARGET_W-1:0]     target_q;
	logic [COUNT_WIDTH-1:0]  res_q;

	logic                    vld_s1;
	logic                    add_s1;
	logic [AW-1:0]           t_s1;
	logic [COUNT_WIDTH-1:0]  rd_a_s1;
	logic [COUNT_WIDTH-1:0]  rd_b_s1;

	logic                    m_tvalid_q;
	logic [RESULT_W-1:0]     m_tdata_q;
	logic                    m_tuser_q;

	logic [COUNT_WIDTH-1:0]  mem [DEPTH];

	logic                    in_beat;
	logic                    add_s0;
	logic [AW-1:0]           rd_b_addr;
	logic [AW-1:0]           tgt_eff;
	logic [COUNT_WIDTH-1:0]  a_eff;
	logic [COUNT_WIDTH-1:0]  b_eff;
	logic [COUNT_WIDTH:0]    sum_w;
	logic                    ovf;
	logic [COUNT_WIDTH-1:0]  new_val;
	logic                    wr_en;
	logic                    out_free;
	logic [RESULT_W-1:0]     res_out;
	logic                    res_big;

	assign s_tready = (state_q == ST_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign tgt_eff = (ELEM_W'(target_q) > ELEM_W'(MAX_TARGET)) ? AW'(MAX_TARGET)
	                                                          : AW'(target_q);

	// entry t takes count[t-v] only when v fits the table and t >= v
	assign add_s0    = (v_q <= ELEM_W'(MAX_TARGET)) && (ELEM_W'(t_q) >= v_q);
	assign rd_b_addr = t_q - v_q[AW-1:0];

	// first element of a set sees the cleared table: entry 0 one, others zero
	always_comb begin
		if (first_q) begin
			a_eff = (t_s1 == '0) ? COUNT_WIDTH'(1) : '0;
			b_eff = (t_s1 == v_q[AW-1:0]) ? COUNT_WIDTH'(1) : '0;
		end else begin
			a_eff = rd_a_s1;
			b_eff = rd_b_s1;
		end
	end

	assign sum_w   = {1'b0, a_eff} + {1'b0, b_eff};
	assign ovf     = add_s1 && sum_w[COUNT_WIDTH];
	assign new_val = !add_s1 ? a_eff : (ovf ? '1 : sum_w[COUNT_WIDTH-1:0]);
	assign wr_en   = vld_s1 && (first_q || add_s1);

	generate
		if (COUNT_WIDTH > RESULT_W) begin : g_wide
			assign res_big = |res_q[COUNT_WIDTH-1:RESULT_W];
			assign res_out = res_big ? '1 : res_q[RESULT_W-1:0];
		end else begin : g_narrow
			assign res_big = 1'b0;
			assign res_out = RESULT_W'(res_q);
		end
	endgenerate

	// table: reads of entries below the write address only, no forwarding needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[t_s1] <= new_val;
		end
		rd_a_s1 <= mem[t_q];
		rd_b_s1 <= mem[rd_b_addr];
	end

	always_ff @(posedge clk) begin
		t_s1   <= t_q;
		add_s1 <= add_s0;
		if (in_beat) begin
			v_q    <= s_tdata;
			last_q <= s_tlast;
		end
		if (vld_s1 && (t_s1 == tgt_eff)) begin
			res_q <= new_val;
		end
		if (state_q == ST_FINISH && last_q && out_free) begin
			m_tdata_q <= res_out;
			m_tuser_q <= sat_q || res_big;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			t_q        <= '0;
			first_q    <= 1'b0;
			pending_q  <= 1'b1;
			sat_q      <= 1'b0;
			target_q   <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SWEEP);
			if (cfg_wen) begin
				target_q <= cfg_wdata;
			end
			if (state_q == ST_FINISH && last_q && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (vld_s1 && ovf && (t_s1 <= tgt_eff)) begin
				sat_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						t_q       <= AW'(MAX_TARGET);
						first_q   <= pending_q;
						pending_q <= 1'b0;
						if (pending_q) begin
							sat_q <= 1'b0;
						end
						state_q   <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (t_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						t_q <= t_q - AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pending_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_drained_before_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !vld_s1)
		else $error("sweep pipeline still busy while accepting an element");

	a_add_source_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && add_s1) |-> (ELEM_W'(t_s1) >= v_q))
		else $error("table update reads below entry zero");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_FINISH && $past(last_q)))
		else $error("result beat raised outside the end of a set");

	a_sweep_holds_element: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |=> $stable(v_q))
		else $error("element changed during its sweep");

endmodule

### dv/subset_sum_count_core_tb.sv
`timescale 1ns / 1ps

module subset_sum_count_core_tb;
	import ssc_pkg::*;

	localparam int MAX_TARGET    = 1023;
	localparam int COUNT_WIDTH   = 32;
	localparam int CLK_PERIOD    = 4;
	localparam int SETTLE_CYCLES = MAX_TARGET + 80;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 70;

	typedef struct packed {
		logic [ELEM_W-1:0] value;
		logic              last;
	} elem_beat_t;

	typedef struct packed {
		logic [RESULT_W-1:0] count;
		logic                sat;
	} set_result_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [ELEM_W-1:0]   s_tdata   = '0;   // elem_value
	logic                s_tlast   = 1'b0; // last_elem
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [RESULT_W-1:0] m_tdata;          // subset_count
	logic                m_tuser;          // count_saturated
	logic                cfg_wen   = 1'b0;
	logic [TARGET_W-1:0] cfg_wdata = '0;   // target_sum

	subset_sum_count_core #(
		.MAX_TARGET (MAX_TARGET),
		.COUNT_WIDTH(COUNT_WIDTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predictor state
	logic [COUNT_WIDTH-1:0] sum_table [0:MAX_TARGET];
	logic [TARGET_W-1:0]    target_reg = '0;
	bit                     set_starting = 1'b1;
	bit                     sat_seen     = 1'b0;

	elem_beat_t  pending_elems[$];
	set_result_t expected_counts[$];
	set_result_t want;
	int          error_count    = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	bit          drain_hold     = 1'b0;

	task automatic fold_element(input logic [ELEM_W-1:0] value, input logic last);
		int          t;
		int          vi;
		logic [COUNT_WIDTH:0] acc;
		set_result_t r;
		vi = value;
		if (set_starting) begin
			for (t = 0; t <= MAX_TARGET; t++)
				sum_table[t] = '0;
			sum_table[0] = COUNT_WIDTH'(1);
			sat_seen = 1'b0;
			set_starting = 1'b0;
		end
		if (vi <= MAX_TARGET) begin
			for (t = MAX_TARGET; t >= vi; t--) begin
				acc = {1'b0, sum_table[t]} + {1'b0, sum_table[t - vi]};
				if (acc[COUNT_WIDTH]) begin
					sum_table[t] = '1;
					if (t <= target_reg)
						sat_seen = 1'b1;
				end else begin
					sum_table[t] = acc[COUNT_WIDTH-1:0];
				end
			end
		end
		if (last) begin
			r.count = sum_table[target_reg];
			r.sat   = sat_seen;
			expected_counts.push_back(r);
			set_starting = 1'b1;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				fold_element(pending_elems[0].value, pending_elems[0].last);
				if (pending_elems[0].last && $urandom_range(7) == 0)
					drain_hold = 1'b1;
				void'(pending_elems.pop_front());
			end
			if (drain_hold && expected_counts.size() == 0)
				drain_hold = 1'b0;
			if (!s_tvalid || s_tready) begin
				if (pending_elems.size() != 0 && !drain_hold &&
						$urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_elems[0].value;
					s_tlast  <= pending_elems[0].last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected result beat count=%0d sat=%0b",
						$time, m_tdata, m_tuser);
					error_count++;
				end else begin
					want = expected_counts.pop_front();
					if (m_tdata !== want.count) begin
						$display("%0t: subset_count expected %0d actual %0d",
							$time, want.count, m_tdata);
						error_count++;
					end
					if (m_tuser !== want.sat) begin
						$display("%0t: count_saturated expected %0b actual %0b",
							$time, want.sat, m_tuser);
						error_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic add_elem(input logic [ELEM_W-1:0] value, input logic last);
		elem_beat_t b;
		b.value = value;
		b.last  = last;
		pending_elems.push_back(b);
	endtask

	task automatic wait_drained();
		while (pending_elems.size() != 0 || s_tvalid || expected_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_target(input int value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value[TARGET_W-1:0];
		@(posedge clk);
		cfg_wen   <= 1'b0;
		target_reg = value[TARGET_W-1:0];
	endtask

	task automatic queue_random_sets(input int n_items);
		int queued;
		int kind;
		int len;
		int i;
		int r;
		logic [ELEM_W-1:0] v;
		queued = 0;
		while (queued < n_items) begin
			kind = $urandom_range(99);
			if (kind < 3) begin
				// long run of tiny values drives counts into saturation
				len = 36;
				for (i = 0; i < len; i++)
					add_elem(ELEM_W'($urandom_range(2)), i == len - 1);
			end else if (kind < 10) begin
				len = 1;
				add_elem(ELEM_W'($urandom()), 1'($urandom_range(1)));
			end else begin
				len = $urandom_range(8, 1);
				for (i = 0; i < len; i++) begin
					r = $urandom_range(9);
					if (r < 6)
						v = ELEM_W'($urandom_range(target_reg));
					else if (r < 8)
						v = ELEM_W'($urandom_range(15));
					else if (r == 8)
						v = ELEM_W'($urandom_range(MAX_TARGET));
					else
						v = ELEM_W'($urandom());
					add_elem(v, i == len - 1);
				end
			end
			queued += len;
		end
	endtask

	int phase_send[PHASES]   = '{0, 0, 65, 65, 0, 0, 16, 16};
	int phase_recv[PHASES]   = '{0, 0, 0, 0, 65, 65, 16, 16};
	int phase_target[PHASES] = '{1023, 0, -1, 7, -1, 1, 512, -1};

	initial begin
		int p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset target of zero, zero elements double entry 0
		@(negedge clk);
		add_elem(16'd0, 1'b0);
		add_elem(16'd0, 1'b1);
		wait_drained();

		set_target(MAX_TARGET);
		@(negedge clk);
		add_elem(16'd1023, 1'b1);
		add_elem(16'hFFFF, 1'b0);
		add_elem(16'd1024, 1'b1);
		add_elem(16'd512, 1'b0);
		add_elem(16'd511, 1'b0);
		add_elem(16'd0, 1'b1);
		wait_drained();

		set_target(5);
		@(negedge clk);
		add_elem(16'd1, 1'b0);
		add_elem(16'd2, 1'b0);
		add_elem(16'd3, 1'b0);
		add_elem(16'd0, 1'b0);
		add_elem(16'd5, 1'b1);
		add_elem(16'd5, 1'b1);
		add_elem(16'd2, 1'b0);
		add_elem(16'd3, 1'b0);
		wait_drained();

		// target moves while a set is open
		set_target(3);
		@(negedge clk);
		add_elem(16'd0, 1'b1);

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			send_idle_pct  = phase_send[p];
			recv_stall_pct = phase_recv[p];
			set_target(phase_target[p] < 0 ? $urandom_range(MAX_TARGET) : phase_target[p]);
			@(negedge clk);
			queue_random_sets(PHASE_ITEMS);
		end
		wait_drained();

		if (error_count == 0 && expected_counts.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

### subset_sum_count_core.f
rtl/core/ssc_pkg.sv
rtl/core/subset_sum_count_core.sv
dv/subset_sum_count_core_tb.sv
